[rtl/rhhs_pkg.sv]
// ----------------------------------------------------------------------------
// rhhs_pkg
// shared types and codes of the robin hood hash set
// ----------------------------------------------------------------------------
`default_nettype none

package rhhs_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_KEY_WIDTH = 32;

  localparam logic [8:0] LOAD_LIMIT_RESET = 9'd192;

  // operation codes
  localparam logic [2:0] MODE_LOOKUP = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // result codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [7:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] key_out;
    logic        occupied;
    logic [8:0]  entry_count;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/rhhs_ram.sv]
// ----------------------------------------------------------------------------
// rhhs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rhhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/robin_hood_hash_set.sv]
// ----------------------------------------------------------------------------
// robin_hood_hash_set
// open-addressed hash set, robin hood probing, backward-shift deletion
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready, req): one operation per transfer, with
//   mode, key and home slot (or bucket index for a bucket read)
//   rsp channel (rsp_valid/rsp_ready, rsp): exactly one result per request
//   cfg channel (cfg_valid/cfg_ready, cfg_load_limit): load limit, always ready
// sequence
//   one operation at a time; every probe step reads one slot word of the slot ram
//   (registered read, next address issued while the current word is checked)
//   lookup / failed insert / remove miss: probe, then result
//   insert: probe, placement steps, then result
//   remove: probe, backward shift of the following entries, then result
//   bucket read: one slot read; clear: every slot emptied in turn, then result
// reset
//   synchronous rst starts a clearing pass that empties every slot;
//   req_ready stays low during it, cfg writes are still taken
// stall
//   a result waits in the output register until taken; the next request is
//   accepted meanwhile, and its own result waits until the register is free
// ----------------------------------------------------------------------------
`default_nettype none

module robin_hood_hash_set #(
  parameter int CAPACITY  = rhhs_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = rhhs_pkg::DEF_KEY_WIDTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire rhhs_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output rhhs_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [8:0]     cfg_load_limit
);

  import rhhs_pkg::*;

  localparam int AW  = $clog2(CAPACITY);        // slot index
  localparam int DW  = $clog2(CAPACITY + 2);    // probe distance plus one
  localparam int CW  = $clog2(CAPACITY + 1);    // entry count
  localparam int LW  = (CW > 9) ? CW : 9;       // count vs limit compare
  localparam int SKW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int RW  = SKW + DW;

  localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_PROBE, S_PLACE, S_SHIFT, S_READ, S_RESULT
  } state_t;

  // slot_index modulo CAPACITY, one restoring step per input bit
  function automatic logic [AW-1:0] home_of(logic [7:0] v);
    logic [AW:0] r;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      r = {r[AW-1:0], v[b]};
      if (r >= CAP_W) begin
        r = r - CAP_W;
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_of(logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  state_t          state;
  logic [2:0]      mode;
  logic [SKW-1:0]  key_r;      // key being searched, or carried during placement
  logic [AW-1:0]   home;
  logic [AW-1:0]   idx;        // slot under test, shift destination, clear pointer
  logic [DW-1:0]   walk_dist;  // walker distance plus one
  logic [CW-1:0]   iter;
  logic [CW-1:0]   count;
  logic [8:0]      load_limit;
  logic            clr_reply;  // clear came from a request, not from reset
  rsp_t            res;

  // slot ram ports
  logic            we;
  logic [AW-1:0]   waddr;
  logic [RW-1:0]   wdata;
  logic [AW-1:0]   raddr;
  logic [RW-1:0]   rdata;

  logic [SKW-1:0]  rd_key;
  logic [DW-1:0]   rd_dist;
  logic [AW-1:0]   idx_nx;
  logic            stop;       // empty slot or richer resident
  logic            key_eq;
  logic            full;
  logic            shift_end;

  assign rd_key    = rdata[DW +: SKW];
  assign rd_dist   = rdata[DW-1:0];
  assign idx_nx    = next_of(idx);
  assign stop      = (rd_dist == '0) || (rd_dist < walk_dist);
  assign key_eq    = (rd_key == key_r);
  assign full      = (LW'(count) >= LW'(load_limit)) || (count == CAP_C);
  assign shift_end = (iter == CAP_C) || (rd_dist <= DW'(1));

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  rhhs_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // ram addressing: the next slot is read while the current word is checked
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {key_r, walk_dist};
    raddr = idx_nx;
    unique case (state)
      S_IDLE: begin
        raddr = home_of(req.slot_index);
      end
      S_PROBE: begin
        // miss on insert: read the stop slot again for placement
        if (stop && mode == MODE_INSERT && !full) begin
          raddr = idx;
        end
      end
      S_PLACE: begin
        we = stop;
      end
      S_SHIFT: begin
        // data of the slot after idx is valid; pull it back into idx
        we    = 1'b1;
        wdata = shift_end ? {rd_key, {DW{1'b0}}} : {rd_key, rd_dist - 1'b1};
        raddr = next_of(idx_nx);
      end
      S_CLR: begin
        we    = 1'b1;
        wdata = {key_r, {DW{1'b0}}};
      end
      S_READ, S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      idx        <= '0;
      count      <= '0;
      load_limit <= LOAD_LIMIT_RESET;
      clr_reply  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        load_limit <= cfg_load_limit;
      end
      // the result state reloads the register itself
      if (rsp_valid && rsp_ready && state != S_RESULT) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          idx <= idx_nx;
          if (idx == LAST) begin
            count     <= '0;
            clr_reply <= 1'b0;
            state     <= clr_reply ? S_RESULT : S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            mode      <= req.mode;
            key_r     <= req.key[SKW-1:0];
            home      <= home_of(req.slot_index);
            idx       <= home_of(req.slot_index);
            walk_dist <= DW'(1);
            iter      <= '0;
            res       <= '{status: ST_DONE, slot: '0, key_out: '0, occupied: 1'b0,
                           entry_count: '0};
            priority case (req.mode)
              MODE_LOOKUP, MODE_INSERT, MODE_REMOVE: state <= S_PROBE;
              MODE_READ: state <= S_READ;
              MODE_CLEAR: begin
                idx       <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: state <= S_RESULT;
            endcase
          end
        end

        S_PROBE: begin
          if (stop) begin
            if (mode == MODE_INSERT) begin
              if (full) begin
                res.status <= ST_FULL;
                state      <= S_RESULT;
              end else begin
                res.status <= ST_INSERTED;
                res.slot   <= 8'(idx);
                state      <= S_PLACE;
              end
            end else begin
              res.status <= ST_NOT_FOUND;
              state      <= S_RESULT;
            end
          end else if (key_eq) begin
            res.slot <= 8'(idx);
            if (mode == MODE_REMOVE) begin
              res.status <= ST_REMOVED;
              iter       <= '0;
              state      <= S_SHIFT;
            end else begin
              res.status <= ST_FOUND;
              state      <= S_RESULT;
            end
          end else if (iter == CAP_C - 1'b1) begin
            // walked the whole table
            res.status <= (mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
            state      <= S_RESULT;
          end else begin
            idx       <= idx_nx;
            walk_dist <= walk_dist + 1'b1;
            iter      <= iter + 1'b1;
          end
        end

        S_PLACE: begin
          if (rd_dist == '0) begin
            count <= count + 1'b1;
            state <= S_RESULT;
          end else if (rd_dist < walk_dist) begin
            // swap with the richer resident and carry it onward
            key_r     <= rd_key;
            walk_dist <= rd_dist + 1'b1;
            idx       <= idx_nx;
          end else begin
            walk_dist <= walk_dist + 1'b1;
            idx       <= idx_nx;
          end
        end

        S_SHIFT: begin
          if (shift_end) begin
            if (count != '0) begin
              count <= count - 1'b1;
            end
            state <= S_RESULT;
          end else begin
            idx  <= idx_nx;
            iter <= iter + 1'b1;
          end
        end

        S_READ: begin
          res.slot <= 8'(home);
          if (rd_dist != '0) begin
            res.occupied <= 1'b1;
            res.key_out  <= 32'(rd_key);
          end
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= '{status: res.status, slot: res.slot, key_out: res.key_out,
                           occupied: res.occupied, entry_count: 9'(count)};
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rhhs_check.sv]
// ----------------------------------------------------------------------------
// rhhs_check
// port-level checks of the robin hood hash set
// ----------------------------------------------------------------------------
`default_nettype none

module rhhs_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire rhhs_pkg::rsp_t rsp
);

  import rhhs_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one operation at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // only a bucket read reports an occupied bucket
  a_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.occupied || rsp.key_out != '0) |-> rsp.status == ST_DONE)
    else $error("bucket data on a non-read result");

  // misses carry slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
      |-> rsp.slot == '0)
    else $error("miss with nonzero slot");

endmodule

bind robin_hood_hash_set rhhs_check u_rhhs_check (.*);

`default_nettype wire
